// ===== rtl/dstp_pkg.sv =====
package dstp_pkg;

  localparam int FRAC_DIGITS_DEF = 4;
  localparam int INT_BITS_DEF    = 16;

  // Width of the fraction digit counter, enough for the largest digit limit.
  localparam int FCNT_W = 3;

  // Width of the scale operand (font size and the unit divisors).
  localparam int MULW = 16;

  localparam logic [15:0] FONT_RESET = 16'd2560;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [15:0] UNIT_STR_PT = "pt";
  localparam logic [15:0] UNIT_STR_CM = "cm";
  localparam logic [15:0] UNIT_STR_MM = "mm";
  localparam logic [15:0] UNIT_STR_IN = "in";
  localparam logic [15:0] UNIT_STR_EM = "em";
  localparam logic [15:0] UNIT_STR_EX = "ex";
  localparam logic [15:0] UNIT_STR_MU = "mu";

  typedef enum logic [2:0] {
    UNIT_NONE = 3'd0,
    UNIT_PT   = 3'd1,
    UNIT_CM   = 3'd2,
    UNIT_MM   = 3'd3,
    UNIT_IN   = 3'd4,
    UNIT_EM   = 3'd5,
    UNIT_EX   = 3'd6,
    UNIT_MU   = 3'd7
  } unit_e;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_EMPTY      = 3'd1,
    STS_SIGN_ONLY  = 3'd2,
    STS_BAD_NUMBER = 3'd3,
    STS_BAD_UNIT   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_SIGNED = 2'd1,
    PH_NUMBER = 2'd2,
    PH_UNIT   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_SCAN      = 3'd0,
    ST_FRAC_GO   = 3'd1,
    ST_FRAC_WAIT = 3'd2,
    ST_MUL_GO    = 3'd3,
    ST_MUL_WAIT  = 3'd4,
    ST_DIV_GO    = 3'd5,
    ST_DIV_WAIT  = 3'd6,
    ST_RESULT    = 3'd7
  } fsm_e;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_sts_t;

  typedef struct packed {
    phase_e phase;
    logic   negative;
    logic   seen_digit;
    logic   unit_bad;
    unit_e  unit_code;
  } scan_flags_t;

  function automatic logic [31:0] pow10_f(input logic [FCNT_W-1:0] n);
    logic [31:0] r;
    r = 32'd1;
    for (int i = 0; i < 7; i++) begin
      if (i < int'(n)) begin
        r = r * 32'd10;
      end
    end
    return r;
  endfunction

  function automatic unit_e unit_decode(input logic [7:0] c0, input logic [7:0] c1);
    case ({c0, c1})
      UNIT_STR_PT: return UNIT_PT;
      UNIT_STR_CM: return UNIT_CM;
      UNIT_STR_MM: return UNIT_MM;
      UNIT_STR_IN: return UNIT_IN;
      UNIT_STR_EM: return UNIT_EM;
      UNIT_STR_EX: return UNIT_EX;
      UNIT_STR_MU: return UNIT_MU;
      default:     return UNIT_NONE;
    endcase
  endfunction

  function automatic logic [MULW-1:0] unit_mul_f(input unit_e u, input logic [15:0] font);
    case (u)
      UNIT_CM: return 16'd3600;
      UNIT_MM: return 16'd360;
      UNIT_IN: return 16'd72;
      UNIT_EM: return font;
      UNIT_EX: return font;
      UNIT_MU: return font;
      default: return 16'd1;
    endcase
  endfunction

  function automatic logic [MULW-1:0] unit_div_f(input unit_e u);
    case (u)
      UNIT_CM: return 16'd127;
      UNIT_MM: return 16'd127;
      UNIT_EM: return 16'd256;
      UNIT_EX: return 16'd512;
      UNIT_MU: return 16'd4608;
      default: return 16'd1;
    endcase
  endfunction

endpackage

// ===== rtl/dstp_scan.sv =====
module dstp_scan #(
  parameter int FRAC_DIGITS = 4,
  parameter int INT_BITS    = 16,
  localparam int IW = INT_BITS + 1,
  localparam int FW = $clog2(10**FRAC_DIGITS)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic                           clear,
  input  logic [7:0]                     ch,
  output dstp_pkg::scan_flags_t          flags,
  output logic [IW-1:0]                  int_accum,
  output logic [FW-1:0]                  frac_accum,
  output logic [dstp_pkg::FCNT_W-1:0]    frac_count
);
  import dstp_pkg::*;

  localparam logic [IW+3:0] INT_MAX = (IW+4)'((64'd1 << INT_BITS) - 64'd1);

  phase_e              phase, phase_next;
  logic                negative, negative_next;
  logic                seen_dot, seen_dot_next;
  logic                seen_digit, seen_digit_next;
  logic [IW-1:0]       int_accum_next;
  logic [FW-1:0]       frac_accum_next;
  logic [FCNT_W-1:0]   frac_count_next;
  logic [7:0]          unit_c0, unit_c0_next;
  logic [7:0]          unit_c1, unit_c1_next;
  logic [1:0]          unit_len, unit_len_next;

  logic                is_digit, is_sign, is_minus, is_dot;
  logic [3:0]          digit;
  logic [IW+3:0]       int_mul;
  logic [FW+3:0]       frac_mul;
  logic                num_char, unit_char;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_minus = (ch == CH_MINUS);
  assign is_sign  = is_minus || (ch == CH_PLUS);
  assign is_dot   = (ch == CH_DOT);
  assign digit    = 4'(ch - CH_ZERO);

  // Multiply by ten as two shifts and an add.
  assign int_mul  = {int_accum, 3'b000} + {2'b00, int_accum, 1'b0} + (IW+4)'(digit);
  assign frac_mul = {frac_accum, 3'b000} + {2'b00, frac_accum, 1'b0} + (FW+4)'(digit);

  always_comb begin
    phase_next      = phase;
    negative_next   = negative;
    seen_dot_next   = seen_dot;
    seen_digit_next = seen_digit;
    int_accum_next  = int_accum;
    frac_accum_next = frac_accum;
    frac_count_next = frac_count;
    unit_c0_next    = unit_c0;
    unit_c1_next    = unit_c1;
    unit_len_next   = unit_len;
    num_char        = 1'b0;
    unit_char       = 1'b0;
    if (clear) begin
      phase_next      = PH_START;
      negative_next   = 1'b0;
      seen_dot_next   = 1'b0;
      seen_digit_next = 1'b0;
      int_accum_next  = '0;
      frac_accum_next = '0;
      frac_count_next = '0;
      unit_c0_next    = '0;
      unit_c1_next    = '0;
      unit_len_next   = '0;
    end else if (take) begin
      case (phase)
        PH_START: begin
          if (is_sign) begin
            negative_next = is_minus;
            phase_next    = PH_SIGNED;
          end else begin
            num_char = 1'b1;
          end
        end
        PH_SIGNED: begin
          if (is_sign) begin
            if (is_minus) begin
              negative_next = ~negative;
            end
            phase_next = PH_NUMBER;
          end else begin
            num_char = 1'b1;
          end
        end
        PH_NUMBER: num_char = 1'b1;
        default:   unit_char = 1'b1;
      endcase

      if (num_char) begin
        if (is_digit) begin
          seen_digit_next = 1'b1;
          phase_next      = PH_NUMBER;
          if (!seen_dot) begin
            // Once the integer part has saturated it stays there.
            if (!int_accum[INT_BITS]) begin
              if (int_mul > INT_MAX) begin
                int_accum_next = IW'(INT_MAX + 1'b1);
              end else begin
                int_accum_next = int_mul[IW-1:0];
              end
            end
          end else if (frac_count < FCNT_W'(FRAC_DIGITS)) begin
            frac_accum_next = frac_mul[FW-1:0];
            frac_count_next = frac_count + 1'b1;
          end
        end else if (is_dot && !seen_dot) begin
          seen_dot_next = 1'b1;
          phase_next    = PH_NUMBER;
        end else begin
          unit_char = 1'b1;
        end
      end

      if (unit_char) begin
        phase_next = PH_UNIT;
        if (unit_len == 2'd0) begin
          unit_c0_next = ch;
        end
        if (unit_len == 2'd1) begin
          unit_c1_next = ch;
        end
        if (unit_len != 2'd3) begin
          unit_len_next = unit_len + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      negative   <= 1'b0;
      seen_dot   <= 1'b0;
      seen_digit <= 1'b0;
      int_accum  <= '0;
      frac_accum <= '0;
      frac_count <= '0;
      unit_c0    <= '0;
      unit_c1    <= '0;
      unit_len   <= '0;
    end else begin
      phase      <= phase_next;
      negative   <= negative_next;
      seen_dot   <= seen_dot_next;
      seen_digit <= seen_digit_next;
      int_accum  <= int_accum_next;
      frac_accum <= frac_accum_next;
      frac_count <= frac_count_next;
      unit_c0    <= unit_c0_next;
      unit_c1    <= unit_c1_next;
      unit_len   <= unit_len_next;
    end
  end

  always_comb begin
    flags.phase      = phase;
    flags.negative   = negative;
    flags.seen_digit = seen_digit;
    flags.unit_code  = (unit_len == 2'd2) ? unit_decode(unit_c0, unit_c1) : UNIT_NONE;
    flags.unit_bad   = (unit_len == 2'd1) || (unit_len == 2'd3) ||
                       ((unit_len == 2'd2) && (flags.unit_code == UNIT_NONE));
  end

endmodule

// ===== rtl/dstp_arith.sv =====
module dstp_arith #(
  parameter int DW = 48,
  parameter int BW = 16,
  parameter int MW = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dstp_pkg::arith_cmd_t   cmd,
  input  logic [DW-1:0]          a,
  input  logic [BW-1:0]          b,
  input  logic [DW-1:0]          bias,
  output dstp_pkg::arith_sts_t   sts,
  output logic [DW-1:0]          res
);
  import dstp_pkg::*;

  localparam int CNTW = $clog2(DW + 1);

  arith_op_e       op;
  logic            busy;
  logic            done;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   acc;
  logic [DW-1:0]   sh;
  logic [BW-1:0]   opb;

  logic [BW:0]     trial;
  logic [DW-1:0]   add_x, add_y;
  logic            add_cin;
  logic [DW:0]     sum;
  logic            last_step;

  // One adder serves both operations: shift-and-add for multiply, and a
  // restoring trial subtract for divide (carry out means no borrow).
  assign trial = {acc[BW-1:0], sh[DW-1]};

  always_comb begin
    if (op == OP_MUL) begin
      add_x   = acc;
      add_y   = opb[0] ? sh : '0;
      add_cin = 1'b0;
    end else begin
      add_x   = {{(DW-BW-1){1'b0}}, trial};
      add_y   = ~{{(DW-BW){1'b0}}, opb};
      add_cin = 1'b1;
    end
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y} + (DW+1)'(add_cin);

  assign last_step = (op == OP_MUL) ? (cnt == CNTW'(MW - 1)) : (cnt == CNTW'(DW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        op   <= cmd.op;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc <= (cmd.op == OP_MUL) ? bias : '0;
      sh  <= a;
      opb <= b;
    end else if (busy) begin
      if (op == OP_MUL) begin
        acc <= sum[DW-1:0];
        sh  <= {sh[DW-2:0], 1'b0};
        opb <= {1'b0, opb[BW-1:1]};
      end else begin
        acc <= sum[DW] ? sum[DW-1:0] : {{(DW-BW-1){1'b0}}, trial};
        sh  <= {sh[DW-2:0], sum[DW]};
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign res      = (op == OP_MUL) ? acc : sh;

endmodule

// ===== rtl/dimension_string_to_points.sv =====
// Length-string parser: turns a string such as "-12.5pt" into points, Q.16.
//
// Input channel (item_valid / item_stall): one transaction per character,
// carrying ch, has_char and last. A transaction with has_char low carries no
// character; with last high it ends the string, after its own character is
// taken. Other characters are taken one per cycle while item_stall is low.
// Result channel (result_valid / result_stall): one transaction per string,
// carrying value_q16, unit_code and status. Error results carry zero value.
// Configuration: cfg_write_en writes cfg_write_data into the font size
// (unsigned Q8.8) used by em, ex and mu. Reset value is 10 pt.
// Finishing: after the last transaction of a string is taken, one shared
// shift-add / restoring-divide unit working one bit per cycle runs a
// fraction divide (DW steps), a unit multiply (16 steps) and a unit divide
// (DW steps), DW being the larger of INT_BITS + 32 and FW + 16. A string
// that ends in error before any arithmetic skips them. item_stall is high
// from then until the result is loaded into the output register.
// The result waits in an output register while result_stall is high; the
// next string may be fed meanwhile, and its result waits until the register
// is free. Reset (rst, synchronous) empties the block and drops any result.
module dimension_string_to_points #(
  parameter int FRAC_DIGITS = dstp_pkg::FRAC_DIGITS_DEF,
  parameter int INT_BITS    = dstp_pkg::INT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [15:0]        cfg_write_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [7:0]         ch,
  input  logic               has_char,
  input  logic               last,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [39:0] value_q16,
  output logic [2:0]         unit_code,
  output logic [2:0]         status
);
  import dstp_pkg::*;

  localparam int IW  = INT_BITS + 1;
  localparam int FW  = $clog2(10**FRAC_DIGITS);
  localparam int PTW = $clog2(10**FRAC_DIGITS + 1);
  localparam int BW  = (PTW > MULW) ? PTW : MULW;
  localparam int NW  = INT_BITS + 17;
  localparam int DW  = ((INT_BITS + 32) > (FW + 16)) ? (INT_BITS + 32) : (FW + 16);

  fsm_e              state, state_next;
  logic [15:0]       font_size_q8;

  scan_flags_t       flags;
  logic [IW-1:0]     int_accum;
  logic [FW-1:0]     frac_accum;
  logic [FCNT_W-1:0] frac_count;

  arith_cmd_t        cmd;
  arith_sts_t        sts;
  logic [DW-1:0]     op_a, op_bias, res;
  logic [BW-1:0]     op_b;

  logic [31:0]       pow10_full;
  logic [PTW-1:0]    pow10;
  logic [FW+15:0]    frac_dividend;
  logic [MULW-1:0]   unit_mul, unit_div;

  status_e           pre_status;
  status_e           status_q;
  logic [NW-1:0]     num;
  logic [38:0]       mag;

  logic              take, finish, load_out;

  assign item_stall = (state != ST_SCAN);
  assign take       = item_valid && !item_stall && has_char;
  assign finish     = item_valid && !item_stall && last;
  assign load_out   = (state == ST_RESULT) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      font_size_q8 <= FONT_RESET;
    end else if (cfg_write_en) begin
      font_size_q8 <= cfg_write_data;
    end
  end

  dstp_scan #(
    .FRAC_DIGITS(FRAC_DIGITS),
    .INT_BITS   (INT_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .clear     (load_out),
    .ch        (ch),
    .flags     (flags),
    .int_accum (int_accum),
    .frac_accum(frac_accum),
    .frac_count(frac_count)
  );

  dstp_arith #(
    .DW(DW),
    .BW(BW),
    .MW(MULW)
  ) u_arith (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .a   (op_a),
    .b   (op_b),
    .bias(op_bias),
    .sts (sts),
    .res (res)
  );

  // Fraction term: frac_accum * 65536 / 10^frac_count, rounded half up.
  assign pow10_full    = pow10_f(frac_count);
  assign pow10         = pow10_full[PTW-1:0];
  assign frac_dividend = {frac_accum, 16'h0000} + (FW+16)'(pow10 >> 1);

  assign unit_mul = unit_mul_f(flags.unit_code, font_size_q8);
  assign unit_div = unit_div_f(flags.unit_code);

  // Status known from the parse alone; bad number outranks a bad unit.
  always_comb begin
    if (flags.phase == PH_START) begin
      pre_status = STS_EMPTY;
    end else if (flags.phase == PH_SIGNED) begin
      pre_status = STS_SIGN_ONLY;
    end else if (!flags.seen_digit || int_accum[INT_BITS]) begin
      pre_status = STS_BAD_NUMBER;
    end else if (flags.unit_bad) begin
      pre_status = STS_BAD_UNIT;
    end else begin
      pre_status = STS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SCAN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.start  = 1'b0;
    cmd.op     = OP_MUL;
    op_a       = '0;
    op_b       = '0;
    op_bias    = '0;
    case (state)
      ST_SCAN: begin
        if (finish) begin
          state_next = ST_FRAC_GO;
        end
      end
      ST_FRAC_GO: begin
        if (pre_status != STS_OK) begin
          state_next = ST_RESULT;
        end else begin
          cmd.start  = 1'b1;
          cmd.op     = OP_DIV;
          op_a       = DW'(frac_dividend);
          op_b       = BW'(pow10);
          state_next = ST_FRAC_WAIT;
        end
      end
      ST_FRAC_WAIT: begin
        if (sts.done) begin
          state_next = ST_MUL_GO;
        end
      end
      ST_MUL_GO: begin
        // The rounding half of the unit divisor rides in as the start value.
        cmd.start  = 1'b1;
        cmd.op     = OP_MUL;
        op_a       = DW'(num);
        op_b       = BW'(unit_mul);
        op_bias    = DW'(unit_div >> 1);
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (sts.done) begin
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.start  = 1'b1;
        cmd.op     = OP_DIV;
        op_a       = res;
        op_b       = BW'(unit_div);
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (load_out) begin
          state_next = ST_SCAN;
        end
      end
      default: state_next = ST_SCAN;
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FRAC_WAIT) && sts.done) begin
      num <= {int_accum[INT_BITS-1:0], 16'h0000} + NW'(res[16:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_q <= STS_OK;
      mag      <= '0;
    end else if (state == ST_FRAC_GO) begin
      status_q <= pre_status;
      mag      <= '0;
    end else if ((state == ST_DIV_WAIT) && sts.done) begin
      // A magnitude that does not fit the 40-bit signed result is a bad number.
      if (|res[DW-1:39]) begin
        status_q <= STS_BAD_NUMBER;
        mag      <= '0;
      end else begin
        mag <= res[38:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value_q16 <= flags.negative ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      unit_code <= (status_q == STS_OK) ? flags.unit_code : UNIT_NONE;
      status    <= status_q;
    end
  end

endmodule

// ===== rtl/dstp_chk.sv =====
module dstp_chk (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              last,
  input logic              result_valid,
  input logic              result_stall,
  input logic signed [39:0] value_q16,
  input logic [2:0]        unit_code,
  input logic [2:0]        status
);
  import dstp_pkg::*;

  // A stalled result transaction keeps its payload.
  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      $stable(value_q16) && $stable(unit_code) && $stable(status))
    else $error("result payload changed while stalled");

  // Any error status comes with a zero value and no unit.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != STS_OK) |-> (value_q16 == 40'sd0) && (unit_code == UNIT_NONE))
    else $error("error result carries a value or unit");

  // Ending a string always starts the finishing sequence, which blocks input.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && last |=> item_stall)
    else $error("input not stalled after end of string");

  // Reset drops any pending result.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind dimension_string_to_points dstp_chk u_dstp_chk (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_stall  (item_stall),
  .last        (last),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .value_q16   (value_q16),
  .unit_code   (unit_code),
  .status      (status)
);

// ===== dv/dimension_string_to_points_test.sv =====
`timescale 1ns / 1ps

module dimension_string_to_points_test;
  import dstp_pkg::*;

  localparam int FRAC_DIGITS = FRAC_DIGITS_DEF;
  localparam int INT_BITS    = INT_BITS_DEF;

  // Largest integer part that converts cleanly; one above it marks saturation.
  localparam logic [INT_BITS:0] INT_TOP = (INT_BITS+1)'((1 << INT_BITS) - 1);
  // Largest magnitude that fits the signed 40-bit result.
  localparam logic [63:0] MAG_TOP = 64'h7F_FFFF_FFFF;

  // Worst-case finishing time of one string, reckoned from the widths, plus margin.
  localparam int RESULT_LATENCY = 2 * (INT_BITS + 32) + 23;
  localparam int SETTLE_CYCLES  = RESULT_LATENCY + 10;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 80;
  localparam int HOLD_AT     = 40;
  localparam int LONG_HOLD   = 500;

  // In the directed table this character stands for a NUL byte, which a
  // string literal cannot carry.
  localparam logic [7:0] NUL_MARK = 8'h7E;

  // One converted length as it leaves the block.
  typedef struct packed {
    logic signed [39:0] value;
    unit_e              unit;
    status_e            sts;
  } length_t;

  // One directed string. With bare set, the string is closed by a separate
  // transaction that carries no character. With noop set, a transaction with
  // neither a character nor an end mark is slipped in after the first
  // character. With typed set, want is the expected result as written here;
  // otherwise the predictor works it out.
  typedef struct {
    string       txt;
    logic [15:0] font;
    bit          bare;
    bit          noop;
    bit          typed;
    length_t     want;
  } plan_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_write_en = 1'b0;
  logic [15:0]        cfg_write_data = '0;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [7:0]         ch = '0;
  logic               has_char = 1'b0;
  logic               last = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [39:0] value_q16;
  logic [2:0]         unit_code;
  logic [2:0]         status;

  dimension_string_to_points dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .ch            (ch),
    .has_char      (has_char),
    .last          (last),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .value_q16     (value_q16),
    .unit_code     (unit_code),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Scanner state of the predictor, mirroring what the block keeps per string.
  phase_e              sc_phase;
  logic                sc_negative;
  logic                sc_dot;
  logic                sc_digit;
  logic [INT_BITS:0]   sc_int;
  logic [13:0]         sc_frac;
  logic [FCNT_W-1:0]   sc_fcnt;
  logic [7:0]          sc_sfx0;
  logic [7:0]          sc_sfx1;
  logic [1:0]          sc_sfxlen;
  logic [15:0]         font_q8;

  // Lengths still owed by the block, oldest first.
  length_t pending_lengths[$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  results_taken = 0;
  bit  sender_idle = 1'b1;
  bit  receiver_idle = 1'b1;

  task automatic restart_scan();
    sc_phase    = PH_START;
    sc_negative = 1'b0;
    sc_dot      = 1'b0;
    sc_digit    = 1'b0;
    sc_int      = '0;
    sc_frac     = '0;
    sc_fcnt     = '0;
    sc_sfx0     = '0;
    sc_sfx1     = '0;
    sc_sfxlen   = '0;
  endtask

  // Everything past the number is collected as the unit suffix. Only the
  // first two characters are kept; the length saturates at three so that
  // any longer suffix is still seen as wrong.
  task automatic sfx_char(input logic [7:0] c);
    sc_phase = PH_UNIT;
    if (sc_sfxlen == 2'd0) sc_sfx0 = c;
    else if (sc_sfxlen == 2'd1) sc_sfx1 = c;
    if (sc_sfxlen != 2'd3) sc_sfxlen = sc_sfxlen + 2'd1;
  endtask

  task automatic number_char(input logic [7:0] c);
    logic [31:0] grown;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      sc_digit = 1'b1;
      sc_phase = PH_NUMBER;
      if (!sc_dot) begin
        // Once the integer part has saturated, further digits are ignored.
        if (sc_int <= INT_TOP) begin
          grown = 32'(sc_int) * 32'd10 + 32'(c - CH_ZERO);
          sc_int = (grown > 32'(INT_TOP)) ? (INT_BITS+1)'(INT_TOP + 1) : grown[INT_BITS:0];
        end
      end else if (sc_fcnt < FRAC_DIGITS) begin
        // Fraction digits past the limit are simply dropped.
        sc_frac = sc_frac * 14'd10 + 14'(c - CH_ZERO);
        sc_fcnt = sc_fcnt + 1'b1;
      end
    end else if (c == CH_DOT && !sc_dot) begin
      sc_dot   = 1'b1;
      sc_phase = PH_NUMBER;
    end else begin
      sfx_char(c);
    end
  endtask

  task automatic scan_char(input logic [7:0] c);
    case (sc_phase)
      PH_START: begin
        if (c == CH_MINUS || c == CH_PLUS) begin
          sc_negative = (c == CH_MINUS);
          sc_phase    = PH_SIGNED;
        end else begin
          number_char(c);
        end
      end
      PH_SIGNED: begin
        // A second sign flips the first one when it is a minus.
        if (c == CH_MINUS || c == CH_PLUS) begin
          if (c == CH_MINUS) sc_negative = !sc_negative;
          sc_phase = PH_NUMBER;
        end else begin
          number_char(c);
        end
      end
      PH_NUMBER: number_char(c);
      default:   sfx_char(c);
    endcase
  endtask

  // Converts the scanned string to its length in points.
  function automatic length_t close_string();
    length_t     r;
    unit_e       u;
    logic [63:0] p10;
    logic [63:0] num;
    logic [63:0] mul;
    logic [63:0] dv;
    logic [63:0] mag;
    logic [39:0] m40;
    r = '0;
    u = UNIT_NONE;
    if (sc_phase == PH_START) begin
      r.sts = STS_EMPTY;
    end else if (sc_phase == PH_SIGNED) begin
      r.sts = STS_SIGN_ONLY;
    end else if (!sc_digit || sc_int > INT_TOP) begin
      r.sts = STS_BAD_NUMBER;
    end else begin
      if (sc_sfxlen == 2'd2) begin
        case ({sc_sfx0, sc_sfx1})
          UNIT_STR_PT: u = UNIT_PT;
          UNIT_STR_CM: u = UNIT_CM;
          UNIT_STR_MM: u = UNIT_MM;
          UNIT_STR_IN: u = UNIT_IN;
          UNIT_STR_EM: u = UNIT_EM;
          UNIT_STR_EX: u = UNIT_EX;
          UNIT_STR_MU: u = UNIT_MU;
          default:     r.sts = STS_BAD_UNIT;
        endcase
      end else if (sc_sfxlen != 2'd0) begin
        r.sts = STS_BAD_UNIT;
      end
      if (r.sts == STS_OK) begin
        p10 = 64'd1;
        for (int k = 0; k < int'(sc_fcnt); k++) p10 = p10 * 64'd10;
        // Fraction to Q.16 with rounding half up, then the unit scale.
        num = (64'(sc_int) << 16) + ((64'(sc_frac) * 64'd65536 + p10 / 2) / p10);
        mul = 64'd1;
        dv  = 64'd1;
        case (u)
          UNIT_CM: begin mul = 64'd3600;      dv = 64'd127;  end
          UNIT_MM: begin mul = 64'd360;       dv = 64'd127;  end
          UNIT_IN: begin mul = 64'd72;        dv = 64'd1;    end
          UNIT_EM: begin mul = 64'(font_q8);  dv = 64'd256;  end
          UNIT_EX: begin mul = 64'(font_q8);  dv = 64'd512;  end
          UNIT_MU: begin mul = 64'(font_q8);  dv = 64'd4608; end
          default: ;
        endcase
        mag = (num * mul + dv / 2) / dv;
        if (mag > MAG_TOP) begin
          r.sts = STS_BAD_NUMBER;
        end else begin
          m40     = mag[39:0];
          r.unit  = u;
          r.value = sc_negative ? (40'd0 - m40) : m40;
        end
      end
    end
    return r;
  endfunction

  // Offers one transaction and holds it until the block takes it. The
  // predictor sees the transaction at the very edge that accepts it.
  task automatic offer_char(input logic [7:0] c, input logic hc, input logic lst,
                            input bit typed, input length_t want);
    int gap;
    gap = sender_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    ch         <= c;
    has_char   <= hc;
    last       <= lst;
    forever begin
      @(posedge clk);
      if (!item_stall) break;
    end
    if (hc) scan_char(c);
    if (lst) begin
      pending_lengths.push_back(typed ? want : close_string());
      restart_scan();
    end
    items_sent++;
  endtask

  // Sends one whole string; an empty one always ends in a bare terminator.
  task automatic send_text(input logic [7:0] txt[$], input bit bare, input bit noop,
                           input bit typed, input length_t want);
    int n;
    n = txt.size();
    for (int i = 0; i < n; i++) begin
      offer_char(txt[i], 1'b1, !bare && (i == n - 1), typed, want);
      if (noop && i == 0) offer_char(8'($urandom), 1'b0, 1'b0, typed, want);
    end
    if (bare || n == 0) offer_char(8'($urandom), 1'b0, 1'b1, typed, want);
  endtask

  // The font size is only changed while the block is idle: every owed
  // result has arrived and the arithmetic has had time to wind down.
  task automatic set_font(input logic [15:0] f);
    item_valid <= 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= f;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    font_q8 = f;
  endtask

  task automatic check_length();
    length_t want;
    if (pending_lengths.size() == 0) begin
      $error("result with nothing owed: value_q16 %0d unit_code %0d status %0d",
             value_q16, unit_code, status);
      mismatches++;
      return;
    end
    want = pending_lengths.pop_front();
    if (value_q16 !== want.value) begin
      $error("value_q16: expected %0d, got %0d", want.value, value_q16);
      mismatches++;
    end
    if (unit_code !== want.unit) begin
      $error("unit_code: expected %0d, got %0d", want.unit, unit_code);
      mismatches++;
    end
    if (status !== want.sts) begin
      $error("status: expected %0d, got %0d", want.sts, status);
      mismatches++;
    end
  endtask

  // Directed strings. Results are typed in where they are obvious (errors,
  // whole points, whole inches); the rest go through the predictor.
  plan_row_t plan[$] = '{
    '{"",              FONT_RESET, 1'b1, 1'b0, 1'b1, '{40'sd0, UNIT_NONE, STS_EMPTY}},
    '{"-",             FONT_RESET, 1'b0, 1'b0, 1'b1, '{40'sd0, UNIT_NONE, STS_SIGN_ONLY}},
    '{"+",             FONT_RESET, 1'b1, 1'b0, 1'b1, '{40'sd0, UNIT_NONE, STS_SIGN_ONLY}},
    '{"--",            FONT_RESET, 1'b0, 1'b0, 1'b1, '{40'sd0, UNIT_NONE, STS_BAD_NUMBER}},
    '{".",             FONT_RESET, 1'b0, 1'b0, 1'b1, '{40'sd0, UNIT_NONE, STS_BAD_NUMBER}},
    '{"pt",            FONT_RESET, 1'b0, 1'b0, 1'b1, '{40'sd0, UNIT_NONE, STS_BAD_NUMBER}},
    '{"1pt",           FONT_RESET, 1'b0, 1'b0, 1'b1, '{40'sd65536, UNIT_PT, STS_OK}},
    '{"-3in",          FONT_RESET, 1'b0, 1'b0, 1'b1, '{-40'sd14155776, UNIT_IN, STS_OK}},
    '{"-+2.5cm",       FONT_RESET, 1'b0, 1'b0, 1'b0, '0},
    '{"--7mm",         FONT_RESET, 1'b0, 1'b0, 1'b0, '0},
    '{"+-0.125in",     FONT_RESET, 1'b0, 1'b0, 1'b0, '0},
    '{"3em",           FONT_RESET, 1'b0, 1'b0, 1'b0, '0},
    '{"12.5ex",        FONT_RESET, 1'b0, 1'b0, 1'b0, '0},
    '{"4mu",           FONT_RESET, 1'b0, 1'b0, 1'b0, '0},
    '{"-.5pt",         FONT_RESET, 1'b0, 1'b0, 1'b0, '0},
    '{"0.123456789pt", FONT_RESET, 1'b0, 1'b0, 1'b0, '0},
    '{"65535.9999pt",  FONT_RESET, 1'b0, 1'b0, 1'b0, '0},
    '{"65535.9999in",  FONT_RESET, 1'b0, 1'b0, 1'b0, '0},
    '{"42",            FONT_RESET, 1'b1, 1'b1, 1'b0, '0},
    '{"1.2.3pt",       FONT_RESET, 1'b0, 1'b0, 1'b1, '{40'sd0, UNIT_NONE, STS_BAD_UNIT}},
    '{"65536pt",       FONT_RESET, 1'b0, 1'b0, 1'b1, '{40'sd0, UNIT_NONE, STS_BAD_NUMBER}},
    '{"99999999",      FONT_RESET, 1'b0, 1'b0, 1'b1, '{40'sd0, UNIT_NONE, STS_BAD_NUMBER}},
    '{"5 pt",          FONT_RESET, 1'b0, 1'b0, 1'b1, '{40'sd0, UNIT_NONE, STS_BAD_UNIT}},
    '{"5pt~",          FONT_RESET, 1'b0, 1'b0, 1'b1, '{40'sd0, UNIT_NONE, STS_BAD_UNIT}},
    '{"7PT",           FONT_RESET, 1'b0, 1'b0, 1'b1, '{40'sd0, UNIT_NONE, STS_BAD_UNIT}},
    '{"8p",            FONT_RESET, 1'b0, 1'b0, 1'b1, '{40'sd0, UNIT_NONE, STS_BAD_UNIT}},
    '{"65535em",       16'hFFFF,   1'b0, 1'b0, 1'b1, '{40'sd0, UNIT_NONE, STS_BAD_NUMBER}},
    '{"-1mu",          16'hFFFF,   1'b0, 1'b0, 1'b0, '0},
    '{"9em",           16'd0,      1'b0, 1'b0, 1'b0, '0}
  };

  // Result side: a random hold-off before each transaction, with stretches
  // of none, and one long hold early in the random part so that the output
  // register fills and the block has to stall its input.
  initial begin : result_side
    int hold;
    forever begin
      if (results_taken == HOLD_AT) hold = LONG_HOLD;
      else hold = receiver_idle ? $urandom_range(0, 6) : 0;
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      forever begin
        @(posedge clk);
        if (result_valid) break;
      end
      check_length();
      results_taken++;
      if (results_taken % 8 == 0) receiver_idle = ($urandom_range(0, 3) != 0);
    end
  end

  // A hung block ends the run here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  txt[$];
    logic [15:0] phase_fonts[6];
    string       pool;
    string       unit_txt[7];
    string       near_top;
    int          phase_start;
    int          strings_done;
    int          kind;
    int          ndig;
    int          pick;
    bit          bare;
    bit          noop;

    pool     = "0123456789.+-ptcminexu ";
    unit_txt = '{"pt", "cm", "mm", "in", "em", "ex", "mu"};
    near_top = "6553";
    phase_fonts = '{FONT_RESET, 16'hFFFF, 16'd0, 16'd1, 16'($urandom), 16'($urandom)};

    restart_scan();
    font_q8 = FONT_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting at the reset font size.
    foreach (plan[r]) begin
      if (plan[r].font != font_q8) set_font(plan[r].font);
      txt.delete();
      for (int k = 0; k < plan[r].txt.len(); k++)
        txt.push_back((plan[r].txt[k] == NUL_MARK) ? 8'h00 : plan[r].txt[k]);
      send_text(txt, plan[r].bare, plan[r].noop, plan[r].typed, plan[r].want);
    end

    // Random part, one stretch per font size. Most strings are well formed
    // with random signs, digits and units; some are corrupted in one place
    // and some are plain noise over the whole byte range.
    strings_done = 0;
    foreach (phase_fonts[p]) begin
      set_font(phase_fonts[p]);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if (strings_done % 8 == 0) sender_idle = ($urandom_range(0, 3) != 0);
        txt.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 7) begin
          case ($urandom_range(0, 3))
            1: txt.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            2: begin
              txt.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
              txt.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            end
            default: ;
          endcase
          // Now and then the integer part sits right at the saturation edge.
          if ($urandom_range(0, 9) == 0) begin
            for (int k = 0; k < 4; k++) txt.push_back(near_top[k]);
            ndig = 1;
          end else begin
            ndig = ($urandom_range(0, 11) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
          end
          repeat (ndig) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 4) < 3) begin
            txt.push_back(CH_DOT);
            repeat ($urandom_range(0, 6)) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          end
          pick = $urandom_range(0, 9);
          if (pick >= 1 && pick <= 7) begin
            txt.push_back(unit_txt[pick - 1][0]);
            txt.push_back(unit_txt[pick - 1][1]);
          end else if (pick >= 8) begin
            repeat ($urandom_range(1, 3)) txt.push_back(pool[$urandom_range(0, pool.len() - 1)]);
          end
          if (kind == 7 && txt.size() > 0) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
        end else begin
          repeat ($urandom_range(0, 7))
            txt.push_back($urandom_range(0, 1) ? 8'($urandom)
                                               : pool[$urandom_range(0, pool.len() - 1)]);
        end
        bare = (txt.size() == 0) || ($urandom_range(0, 5) == 0);
        noop = ($urandom_range(0, 7) == 0);
        send_text(txt, bare, noop, 1'b0, '0);
        strings_done++;
      end
    end

    // Drain: everything owed must arrive, then a quiet stretch catches any
    // stray result.
    item_valid <= 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
